FILE: src/gse_pkg.sv
// Shared types and constants of the gray Sobel edge filter.
// No dependencies; every other file of the block but gse_ram imports it.
package gse_pkg;

	localparam int MAX_LINE  = 2048;
	localparam int LINE_AW   = $clog2(MAX_LINE);
	localparam int ROW_W     = 12;
	localparam int FW_W      = 12;
	localparam int FH_W      = 13;
	localparam int WT_W      = 8;
	localparam int PIX_W     = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 13;
	localparam int SUM_W     = 18;

	localparam logic [FW_W-1:0] FW_MIN   = FW_W'(3);
	localparam logic [FW_W-1:0] FW_MAX   = FW_W'(MAX_LINE);
	localparam logic [FH_W-1:0] FH_MIN   = FH_W'(3);
	localparam logic [FH_W-1:0] FH_MAX   = FH_W'(4096);
	localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
	localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);
	localparam logic [WT_W-1:0] WB_RESET = WT_W'(7);
	localparam logic [WT_W-1:0] WG_RESET = WT_W'(71);
	localparam logic [WT_W-1:0] WR_RESET = WT_W'(21);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_BLUE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_GREEN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_RED   = 3'd4;

	// divide by 100: sums at or above GRAY_SAT clip to 255, below it
	// floor(s/100) == (s * DIV_K) >> DIV_SH holds exactly
	localparam logic [SUM_W-1:0] GRAY_SAT = SUM_W'(25600);
	localparam int               DIV_IN_W = 15;
	localparam int               DIV_K_W  = 13;
	localparam logic [DIV_K_W-1:0] DIV_K  = 13'd5243;
	localparam int               DIV_SH   = 19;
	localparam int               DIV_P_W  = DIV_IN_W + DIV_K_W;

	typedef struct packed {
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
	} pixel_t;

	typedef struct packed {
		logic [PIX_W-1:0]   edge_value;
		logic [ROW_W-1:0]   out_row;
		logic [LINE_AW-1:0] out_col;
		logic               frame_last;
	} result_t;

	typedef struct packed {
		logic [WT_W-1:0] wb;
		logic [WT_W-1:0] wg;
		logic [WT_W-1:0] wr;
	} weights_t;

	// per-item bookkeeping that rides along the pipe
	typedef struct packed {
		logic [LINE_AW-1:0] col;
		logic               emit;
		logic [ROW_W-1:0]   row_o;
		logic [LINE_AW-1:0] col_o;
		logic               last;
	} tag_t;

	// stage advance strobes
	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
	} pipe_ctl_t;

endpackage

FILE: src/gse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module gse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/gse_gray.sv
// Gray conversion: weighted sum in stage 1, divide by 100 with clip in stage 2.
// Depends on gse_pkg.
module gse_gray
	import gse_pkg::*;
(
	input  logic             clk,
	input  pipe_ctl_t        ctl,
	input  weights_t         wts,
	input  pixel_t           pix_s1,
	output logic [PIX_W-1:0] gray_s2
);

	logic [SUM_W-1:0]   sum_c;
	logic [SUM_W-1:0]   sum_s2;
	logic [DIV_P_W-1:0] prod;

	assign sum_c = SUM_W'(wts.wb * pix_s1.blue)
	             + SUM_W'(wts.wg * pix_s1.green)
	             + SUM_W'(wts.wr * pix_s1.red);

	always_ff @(posedge clk) begin
		if (ctl.en1) begin
			sum_s2 <= sum_c;
		end
	end

	// reciprocal multiply, exact below the clip point
	assign prod = DIV_P_W'(sum_s2[DIV_IN_W-1:0]) * DIV_P_W'(DIV_K);

	always_comb begin
		if (sum_s2 >= GRAY_SAT) begin
			gray_s2 = '1;
		end else begin
			gray_s2 = prod[DIV_SH +: PIX_W];
		end
	end

endmodule

FILE: src/gse_window.sv
// 3x3 gray window and combined Sobel X+Y kernel.
// Depends on gse_pkg. Only the two newest columns are kept; the oldest
// column of the shifted window comes from column 1 here.
module gse_window
	import gse_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [PIX_W-1:0] older,
	input  logic [PIX_W-1:0] newer,
	input  logic [PIX_W-1:0] gray,
	output logic [PIX_W-1:0] edge_value
);

	// win_q[line][k]: k=0 is window column 1, k=1 is column 2 (newest)
	logic [PIX_W-1:0] win_q [3][2];
	logic [PIX_W+1:0] pos_sum;
	logic [PIX_W+1:0] neg_sum;
	logic [PIX_W+1:0] diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= '0;
				win_q[i][1] <= '0;
			end
		end else if (en) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
			end
			win_q[0][1] <= older;
			win_q[1][1] <= newer;
			win_q[2][1] <= gray;
		end
	end

	// Gx+Gy = {2,2,0; 2,0,-2; 0,-2,-2} over the shifted window
	assign pos_sum = (PIX_W+2)'(win_q[0][0]) + (PIX_W+2)'(win_q[0][1])
	               + (PIX_W+2)'(win_q[1][0]);
	assign neg_sum = (PIX_W+2)'(newer) + (PIX_W+2)'(win_q[2][1]) + (PIX_W+2)'(gray);
	assign diff    = pos_sum - neg_sum;

	always_comb begin
		if (pos_sum <= neg_sum) begin
			edge_value = '0;
		end else if (diff >= (PIX_W+2)'(128)) begin
			edge_value = '1;
		end else begin
			edge_value = {diff[PIX_W-2:0], 1'b0};
		end
	end

endmodule

FILE: src/gray_sobel_edge_filter_core.sv
// Top level of the gray Sobel edge filter: control, counters, line memory.
// Depends on gse_pkg, gse_ram, gse_gray and gse_window.
//
// Usage:
//   in channel  : one BGR pixel per transfer (in_pixel), raster order.
//   out channel : one result per interior pixel (out_result): Sobel X+Y
//                 magnitude clamped to 0..255, centre row/column, and a flag
//                 on the last interior pixel of the frame. Border pixels,
//                 and the first two rows and columns, give no transfer.
//   config port : wr_en/wr_index/wr_data, one register per cycle, no wait;
//                 write only while the block is idle.
// Pipeline: after the pixel that completes a window is accepted, its result is
//   built by the weighted sum, the divide, then the window into the output reg.
// Throughput: one pixel per cycle while out_stall stays low. The single line
//   memory holds both previous lines per column and takes one read and one
//   write per cycle; the write for a column lands before it is read again.
// Reset: counters back to row 0, column 0, window cleared, registers to
//   640x480 and weights 7/71/21. Line memory is not cleared.
// Stall: the pipe is elastic. While out_stall holds a result, the earlier
//   stages keep filling; in_stall rises once all stages are occupied.
module gray_sobel_edge_filter_core
	import gse_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  pixel_t               in_pixel,
	output logic                 out_valid,
	input  logic                 out_stall,
	output result_t              out_result,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_DAT_W-1:0] wr_data
);

	// configuration
	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;
	weights_t        wts_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_RESET;
			frame_height_q <= FH_RESET;
			wts_q.wb       <= WB_RESET;
			wts_q.wg       <= WG_RESET;
			wts_q.wr       <= WR_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_FRAME_WIDTH:  frame_width_q  <= wr_data[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= wr_data[FH_W-1:0];
				REG_WEIGHT_BLUE:  wts_q.wb       <= wr_data[WT_W-1:0];
				REG_WEIGHT_GREEN: wts_q.wg       <= wr_data[WT_W-1:0];
				REG_WEIGHT_RED:   wts_q.wr       <= wr_data[WT_W-1:0];
				default: ;
			endcase
		end
	end

	// effective geometry, clamped
	logic [FW_W-1:0] w_last;
	logic [FH_W-1:0] h_last;

	always_comb begin
		if (frame_width_q < FW_MIN) begin
			w_last = FW_MIN - FW_W'(1);
		end else if (frame_width_q > FW_MAX) begin
			w_last = FW_MAX - FW_W'(1);
		end else begin
			w_last = frame_width_q - FW_W'(1);
		end
		if (frame_height_q < FH_MIN) begin
			h_last = FH_MIN - FH_W'(1);
		end else if (frame_height_q > FH_MAX) begin
			h_last = FH_MAX - FH_W'(1);
		end else begin
			h_last = frame_height_q - FH_W'(1);
		end
	end

	// pipe control: each stage moves when the next one is free or moving
	pipe_ctl_t ctl;
	logic      v1_q, v2_q, v3_q;
	logic      accept;
	logic      free1, free2, free3;
	tag_t      tag_s1, tag_s2, tag_s3;

	assign ctl.en3 = v3_q && (!out_valid || !out_stall);
	assign free3   = !v3_q || ctl.en3;
	assign ctl.en2 = v2_q && free3;
	assign free2   = !v2_q || ctl.en2;
	assign ctl.en1 = v1_q && free2;
	assign free1   = !v1_q || ctl.en1;
	assign in_stall = !free1;
	assign accept   = in_valid && free1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q      <= 1'b0;
			v2_q      <= 1'b0;
			v3_q      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (free1) begin
				v1_q <= in_valid;
			end
			if (free2) begin
				v2_q <= ctl.en1;
			end
			if (free3) begin
				v3_q <= ctl.en2;
			end
			if (ctl.en3) begin
				out_valid <= tag_s3.emit;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// raster position
	logic [LINE_AW-1:0] col_q;
	logic [ROW_W-1:0]   row_q;
	logic               end_line;
	logic               end_frame;

	assign end_line  = {1'b0, col_q} >= w_last;
	assign end_frame = end_line && ({1'b0, row_q} >= h_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (end_line) begin
				col_q <= '0;
				row_q <= end_frame ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + LINE_AW'(1);
			end
		end
	end

	// stage 1: pixel and tag; line memory read issued at accept
	pixel_t pix_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1       <= in_pixel;
			tag_s1.col   <= col_q;
			tag_s1.emit  <= (row_q >= ROW_W'(2)) && (col_q >= LINE_AW'(2));
			tag_s1.row_o <= row_q - ROW_W'(1);
			tag_s1.col_o <= col_q - LINE_AW'(1);
			tag_s1.last  <= end_frame;
		end
	end

	// line memory: [15:8] line row-2, [7:0] line row-1
	logic [2*PIX_W-1:0] rd_data;
	logic [2*PIX_W-1:0] rd_s2;
	logic [PIX_W-1:0]   gray_s2;

	gse_ram #(
		.WIDTH (2*PIX_W),
		.DEPTH (MAX_LINE)
	) u_line_ram (
		.clk   (clk),
		.we    (ctl.en2),
		.waddr (tag_s2.col),
		.wdata ({rd_s2[PIX_W-1:0], gray_s2}),
		.re    (accept),
		.raddr (col_q),
		.rdata (rd_data)
	);

	gse_gray u_gray (
		.clk     (clk),
		.ctl     (ctl),
		.wts     (wts_q),
		.pix_s1  (pix_s1),
		.gray_s2 (gray_s2)
	);

	// stage 2: read data held while the sum is divided; write-back on exit
	always_ff @(posedge clk) begin
		if (ctl.en1) begin
			rd_s2  <= rd_data;
			tag_s2 <= tag_s1;
		end
	end

	// stage 3: gray and both line taps, into the window on exit
	logic [PIX_W-1:0] older_s3, newer_s3, gray_s3;
	logic [PIX_W-1:0] edge_c;

	always_ff @(posedge clk) begin
		if (ctl.en2) begin
			older_s3 <= rd_s2[2*PIX_W-1:PIX_W];
			newer_s3 <= rd_s2[PIX_W-1:0];
			gray_s3  <= gray_s2;
			tag_s3   <= tag_s2;
		end
	end

	gse_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (ctl.en3),
		.older      (older_s3),
		.newer      (newer_s3),
		.gray       (gray_s3),
		.edge_value (edge_c)
	);

	// output register
	always_ff @(posedge clk) begin
		if (ctl.en3) begin
			out_result.edge_value <= edge_c;
			out_result.out_row    <= tag_s3.row_o;
			out_result.out_col    <= tag_s3.col_o;
			out_result.frame_last <= tag_s3.last;
		end
	end

endmodule

FILE: dv/edge_result_checker.sv
// Prediction and checking for the gray Sobel edge filter testbench.
// Watches the pixel, result and register-write ports; depends on gse_pkg only.
`timescale 1ns / 100ps

module edge_result_checker
	import gse_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  pixel_t               in_pixel,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  result_t              out_result,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_DAT_W-1:0] wr_data,
	output int                   fail_count,
	output int                   pending,
	output int                   edges_seen,
	output logic [ROW_W-1:0]     pos_row,
	output logic [LINE_AW-1:0]   pos_col
);

	logic [FW_W-1:0]    frame_w;
	logic [FH_W-1:0]    frame_h;
	weights_t           wts;
	logic [PIX_W-1:0]   line_old [MAX_LINE];
	logic [PIX_W-1:0]   line_new [MAX_LINE];
	logic [PIX_W-1:0]   win [3][3];   // [line][column], line 0 oldest
	logic [LINE_AW-1:0] col_cnt;
	logic [ROW_W-1:0]   row_cnt;
	result_t            expected_edges [$];

	assign pos_row = row_cnt;
	assign pos_col = col_cnt;

	function automatic int clamp(input int v, input int lo, input int hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic logic [PIX_W-1:0] gray_of(input pixel_t px);
		int sum;
		sum = int'(wts.wb) * int'(px.blue) + int'(wts.wg) * int'(px.green)
			+ int'(wts.wr) * int'(px.red);
		sum = sum / 100;
		return (sum > 255) ? PIX_W'(255) : PIX_W'(sum);
	endfunction

	// Advances line memory, window and raster counters by one pixel.
	// Returns 1 when the pixel completes an interior window.
	function automatic bit filter_pixel(input pixel_t px, output result_t res);
		int w, h, col, row, pos, neg, acc;
		logic [PIX_W-1:0] g;
		bit end_line, emit;
		w = clamp(int'(frame_w), int'(FW_MIN), int'(FW_MAX));
		h = clamp(int'(frame_h), int'(FH_MIN), int'(FH_MAX));
		col = int'(col_cnt);
		row = int'(row_cnt);
		g = gray_of(px);
		end_line = (col >= w - 1);
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = line_old[col];
		win[1][2] = line_new[col];
		win[2][2] = g;
		line_old[col] = line_new[col];
		line_new[col] = g;

		emit = (row >= 2) && (col >= 2);
		res = '0;
		if (emit) begin
			// Gx + Gy folded into one kernel: +2 on the upper-left taps,
			// -2 on the lower-right ones, zero on the anti-diagonal
			pos = int'(win[0][0]) + int'(win[0][1]) + int'(win[1][0]);
			neg = int'(win[1][2]) + int'(win[2][1]) + int'(win[2][2]);
			acc = 2 * (pos - neg);
			res.edge_value = (acc > 255) ? PIX_W'(255) : ((acc < 0) ? '0 : PIX_W'(acc));
			res.out_row    = ROW_W'(row - 1);
			res.out_col    = LINE_AW'(col - 1);
			res.frame_last = end_line && (row >= h - 1);
		end

		if (end_line) begin
			col_cnt = '0;
			row_cnt = (row >= h - 1) ? '0 : ROW_W'(row + 1);
		end else begin
			col_cnt = LINE_AW'(col + 1);
		end
		return emit;
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			fail_count++;
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		result_t want;
		if (!arst_n) begin
			frame_w = FW_RESET;
			frame_h = FH_RESET;
			wts     = '{wb: WB_RESET, wg: WG_RESET, wr: WR_RESET};
			for (int i = 0; i < MAX_LINE; i++) begin
				line_old[i] = '0;
				line_new[i] = '0;
			end
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					win[i][j] = '0;
			col_cnt = '0;
			row_cnt = '0;
			expected_edges.delete();
			pending = 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_FRAME_WIDTH:  frame_w = wr_data[FW_W-1:0];
					REG_FRAME_HEIGHT: frame_h = wr_data[FH_W-1:0];
					REG_WEIGHT_BLUE:  wts.wb  = wr_data[WT_W-1:0];
					REG_WEIGHT_GREEN: wts.wg  = wr_data[WT_W-1:0];
					REG_WEIGHT_RED:   wts.wr  = wr_data[WT_W-1:0];
					default: ;
				endcase
			end

			if (in_valid && !in_stall) begin
				if (filter_pixel(in_pixel, want))
					expected_edges.push_back(want);
			end

			if (out_valid && !out_stall) begin
				edges_seen++;
				if (expected_edges.size() == 0) begin
					fail_count++;
					$error("edge result %0d at row %0d col %0d with nothing outstanding",
						out_result.edge_value, out_result.out_row, out_result.out_col);
				end else begin
					want = expected_edges.pop_front();
					check_field("edge_value", want.edge_value, out_result.edge_value);
					check_field("out_row", want.out_row, out_result.out_row);
					check_field("out_col", want.out_col, out_result.out_col);
					check_field("frame_last", want.frame_last, out_result.frame_last);
				end
			end
			pending = expected_edges.size();
		end
	end

endmodule

FILE: dv/testbench.sv
// Top of the gray Sobel edge filter testbench: clock, reset, pixel stimulus,
// register programming and verdict. Depends on gse_pkg, the filter core and
// edge_result_checker.
`timescale 1ns / 100ps

module testbench;
	import gse_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	pixel_t               in_pixel = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	result_t              out_result;
	logic                 wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = '0;
	logic [CFG_DAT_W-1:0] wr_data = '0;

	int                   fail_count;
	int                   pending;
	int                   edges_seen;
	logic [ROW_W-1:0]     pos_row;
	logic [LINE_AW-1:0]   pos_col;

	// no random idling on either side while set
	bit calm = 1'b0;
	// effective geometry as last programmed, after clamping
	int cur_w = FW_RESET;
	int cur_h = FH_RESET;
	int pixels_sent = 0;
	int settings = 0;

	gray_sobel_edge_filter_core i_dut (.*);

	edge_result_checker i_checker (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#(3_000_000);
		$display("Mismatches found");
		$finish;
	end

	// result side: stall about a third of the time unless calm
	always @(posedge clk)
		out_stall <= idle_roll();

	function automatic bit idle_roll();
		return !calm && ($urandom_range(0, 99) < 32);
	endfunction

	function automatic int clamp(input int v, input int lo, input int hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// pixels left until the counters return to row 0, column 0; a counter
	// at or past its last value wraps at the end of the current line
	function automatic int pixels_to_frame_end();
		int line_left;
		line_left = (int'(pos_col) >= cur_w - 1) ? 1 : cur_w - int'(pos_col);
		if (int'(pos_row) >= cur_h - 1)
			return line_left;
		return line_left + (cur_h - 1 - int'(pos_row)) * cur_w;
	endfunction

	// channel levels lean on black and white so edges clip both ways
	function automatic logic [PIX_W-1:0] rand_level();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom);
		endcase
	endfunction

	function automatic pixel_t rand_pixel();
		return {rand_level(), rand_level(), rand_level()};
	endfunction

	// mostly modest weights, sometimes the extremes, sometimes junk in the
	// bits above the register width
	function automatic logic [CFG_DAT_W-1:0] rand_weight();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return CFG_DAT_W'(255);
			2: return CFG_DAT_W'($urandom);
			default: return CFG_DAT_W'($urandom_range(0, 60));
		endcase
	endfunction

	// one transfer; valid stays up across back-to-back pixels
	task automatic send_pixel(input pixel_t px);
		while (idle_roll()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_pixel <= px;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pixels_sent++;
	endtask

	task automatic send_pixels(input int n);
		repeat (n)
			send_pixel(rand_pixel());
	endtask

	// drains every outstanding result, then lets border pixels still in
	// the pipe clear before the registers are touched
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
	endtask

	// leaves wr_en high; program_regs drops it after the last write
	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
	endtask

	task automatic program_regs(input int fw, input int fh, input int wb, input int wg,
		input int wr);
		set_reg(REG_FRAME_WIDTH, CFG_DAT_W'(fw));
		set_reg(REG_FRAME_HEIGHT, CFG_DAT_W'(fh));
		set_reg(REG_WEIGHT_BLUE, CFG_DAT_W'(wb));
		set_reg(REG_WEIGHT_GREEN, CFG_DAT_W'(wg));
		set_reg(REG_WEIGHT_RED, CFG_DAT_W'(wr));
		wr_en <= 1'b0;
		cur_w = clamp(int'(FW_W'(fw)), int'(FW_MIN), int'(FW_MAX));
		cur_h = clamp(int'(FH_W'(fh)), int'(FH_MIN), int'(FH_MAX));
		settings++;
	endtask

	initial begin
		int     n;
		int     fw;
		int     fh;
		int     phase;
		int     random_px;
		bit     at_start;
		pixel_t px;

		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		// Spare register indexes take a write and must change nothing.
		for (int k = int'(REG_WEIGHT_RED) + 1; k < 2 ** CFG_IDX_W; k++)
			set_reg(CFG_IDX_W'(k), CFG_DAT_W'($urandom));

		// 3x3 frame, width and height written below range (clamp to 3),
		// all weights at max so a white pixel saturates the gray.
		// White on the positive taps only: edge clips high.
		program_regs(0, 2, 255, 255, 255);
		for (int k = 0; k < 9; k++) begin
			px = (k == 0 || k == 1 || k == 3) ? '1 : '0;
			send_pixel(px);
		end
		settle();

		// Blue-only gray; bright pixels on the negative taps: edge clips to 0.
		program_regs(3, 3, 100, 0, 0);
		for (int k = 0; k < 9; k++) begin
			px = rand_pixel();
			px.blue = (k == 5 || k == 7 || k == 8) ? '1 : '0;
			send_pixel(px);
		end
		settle();

		// Height above range (clamps to 4096), then cut back to 3 while the
		// row counter is already past the new last row: the frame must end
		// with the line in progress and flag its last interior pixel.
		program_regs(3, 8191, WB_RESET, WG_RESET, WR_RESET);
		send_pixels(10);
		settle();
		program_regs(3, 3, WB_RESET, WG_RESET, WR_RESET);
		send_pixels(3);
		settle();

		// Width written above range (clamps to 2048): the first line runs
		// well past column 3, then the width is cut to 3 with the column
		// counter past its new last value, so the line ends on the next pixel.
		program_regs(4095, 3, rand_weight(), rand_weight(), rand_weight());
		send_pixels(40);
		settle();
		program_regs(3, 3, rand_weight(), rand_weight(), rand_weight());
		send_pixels(pixels_to_frame_end());

		// Random part. Width only grows at a frame boundary, so every line
		// memory entry inside the window has been written this frame.
		phase = 0;
		random_px = 0;
		while (random_px < 370) begin
			settle();
			at_start = (pos_row == 0) && (pos_col == 0);
			if (!at_start)
				fw = $urandom_range(0, cur_w);
			else if ($urandom_range(0, 7) == 0)
				fw = $urandom_range(0, 2);
			else
				fw = $urandom_range(3, 10);
			if (phase != 2 && $urandom_range(0, 9) == 0)
				fh = $urandom_range(4096, 8191);
			else
				fh = $urandom_range(0, 8);
			program_regs(fw, fh, rand_weight(), rand_weight(), rand_weight());

			// one long run with no idling on either side
			calm = (phase == 2);
			n = pixels_to_frame_end();
			if (calm) begin
				while (n < 150)
					n += cur_w * cur_h;
			end else if (n > 150 || $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 40);
			end else if ($urandom_range(0, 1) == 1) begin
				n += cur_w * cur_h;
			end
			send_pixels(n);
			calm = 1'b0;
			random_px += n;
			phase++;
		end
		settle();

		$display("Ran %0d pixels over %0d register settings; %0d edge results compared.",
			pixels_sent, settings, edges_seen);
		$display("Widths from 3 up to the 2048 clamp, clipped gray and edges, geometry cut mid-frame.");
		if (fail_count == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
